>>> rtl/mdc22_pkg.sv
// shared types and constants for the clause-22 management bus master
package mdc22_pkg;

  // widths of the beat fields
  localparam int unsigned FuncW     = 2;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 16;
  localparam int unsigned PreW      = 6;
  localparam int unsigned PosW      = 7;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 24;

  // frame layout
  localparam logic [PreW-1:0] PreambleReset = 6'd40;
  localparam logic [PosW-1:0] HeaderBits    = 7'd14;
  localparam logic [PosW-1:0] ReadTail      = 7'd17;
  localparam logic [PosW-1:0] WriteTail     = 7'd18;

  // function codes carried in tuser
  typedef enum logic [FuncW-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } func_e;

  // one result beat
  typedef struct packed {
    logic             clock_pulse;
    logic             drive_enable;
    logic             drive_level;
    logic             busy;
    logic             done;
    logic [DataW-1:0] read_data;
  } res_t;

endpackage

>>> rtl/mdc22_sequencer.sv
// bit-period sequencer: transaction state and per-period line control
module mdc22_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [mdc22_pkg::FuncW-1:0]   func_i,
  input  logic [mdc22_pkg::AddrW-1:0]   phy_address_i,
  input  logic [mdc22_pkg::AddrW-1:0]   reg_address_i,
  input  logic [mdc22_pkg::DataW-1:0]   write_data_i,
  input  logic                          data_line_in_i,
  input  logic [mdc22_pkg::PreW-1:0]    preamble_i,
  output mdc22_pkg::res_t               res_o
);

  logic                            active_q, active_d;
  logic                            is_read_q, is_read_d;
  logic [mdc22_pkg::PosW-1:0]      pos_q, pos_d;
  logic [2*mdc22_pkg::AddrW-1:0]   addr_sh_q, addr_sh_d;
  logic [mdc22_pkg::DataW-1:0]     wr_sh_q, wr_sh_d;
  logic [mdc22_pkg::DataW-1:0]     rd_sh_q, rd_sh_d;

  logic                            start;
  logic                            cur_read;
  logic [mdc22_pkg::PosW-1:0]      cur_pos;
  logic [2*mdc22_pkg::AddrW-1:0]   cur_addr;
  logic [mdc22_pkg::DataW-1:0]     cur_wr;
  logic [mdc22_pkg::DataW-1:0]     cur_rd;
  logic [mdc22_pkg::PosW-1:0]      pre_ext;
  logic [mdc22_pkg::PosW-1:0]      hdr_end;
  logic [mdc22_pkg::PosW-1:0]      k_hdr;
  logic [mdc22_pkg::PosW-1:0]      k_tail;
  logic                            en, lvl, done;

  // a start is taken only while idle
  always_comb begin
    case (mdc22_pkg::func_e'(func_i))
      mdc22_pkg::FUNC_READ, mdc22_pkg::FUNC_WRITE: start = !active_q;
      default:                                     start = 1'b0;
    endcase
  end

  // working view of the state for this period
  assign cur_read = start ? (mdc22_pkg::func_e'(func_i) == mdc22_pkg::FUNC_READ) : is_read_q;
  assign cur_pos  = start ? '0 : pos_q;
  assign cur_addr = start ? {phy_address_i, reg_address_i} : addr_sh_q;
  assign cur_wr   = start ? write_data_i : wr_sh_q;
  assign cur_rd   = start ? '0 : rd_sh_q;

  assign pre_ext = {1'b0, preamble_i};
  assign hdr_end = pre_ext + mdc22_pkg::HeaderBits;
  assign k_hdr   = cur_pos - pre_ext;
  assign k_tail  = cur_pos - hdr_end;

  // line control and shift updates for one bit period
  always_comb begin
    en        = 1'b1;
    lvl       = 1'b0;
    done      = 1'b0;
    addr_sh_d = cur_addr;
    wr_sh_d   = cur_wr;
    rd_sh_d   = cur_rd;
    if (cur_pos < pre_ext) begin
      lvl = 1'b1;
    end else if (cur_pos < hdr_end) begin
      case (k_hdr)
        7'd0:    lvl = 1'b0;
        7'd1:    lvl = 1'b1;
        7'd2:    lvl = cur_read;
        7'd3:    lvl = !cur_read;
        default: begin
          lvl       = cur_addr[2*mdc22_pkg::AddrW-1];
          addr_sh_d = {cur_addr[2*mdc22_pkg::AddrW-2:0], 1'b0};
        end
      endcase
    end else if (cur_read) begin
      en = 1'b0;
      if (k_tail >= mdc22_pkg::ReadTail) begin
        done = 1'b1;
      end else if (k_tail != '0) begin
        rd_sh_d = {cur_rd[mdc22_pkg::DataW-2:0], data_line_in_i};
      end
    end else begin
      if (k_tail >= mdc22_pkg::WriteTail) begin
        en   = 1'b0;
        done = 1'b1;
      end else if (k_tail == 7'd0) begin
        lvl = 1'b1;
      end else if (k_tail == 7'd1) begin
        lvl = 1'b0;
      end else begin
        lvl     = cur_wr[mdc22_pkg::DataW-1];
        wr_sh_d = {cur_wr[mdc22_pkg::DataW-2:0], 1'b0};
      end
    end
  end

  // next control state
  always_comb begin
    active_d  = active_q;
    is_read_d = is_read_q;
    pos_d     = pos_q;
    if (active_q || start) begin
      is_read_d = cur_read;
      active_d  = !done;
      pos_d     = done ? '0 : cur_pos + 7'd1;
    end
  end

  // result of this period
  always_comb begin
    res_o              = '0;
    if (active_q || start) begin
      res_o.clock_pulse  = 1'b1;
      res_o.drive_enable = en;
      res_o.drive_level  = en & lvl;
      res_o.busy         = !done;
      res_o.done         = done;
      res_o.read_data    = (done && cur_read) ? cur_rd : '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      is_read_q <= 1'b0;
      pos_q     <= '0;
    end else if (step_i) begin
      active_q  <= active_d;
      is_read_q <= is_read_d;
      pos_q     <= pos_d;
    end
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    if (step_i && (active_q || start)) begin
      addr_sh_q <= addr_sh_d;
      wr_sh_q   <= wr_sh_d;
      rd_sh_q   <= rd_sh_d;
    end
  end

endmodule

>>> rtl/mdio_clause22_master.sv
// top level of the clause-22 management bus master
//
//   channel   direction  tdata                                        tuser  tlast
//   s_axis    in         phy, reg, write data, line level             func   -
//   m_axis    out        clock, drive en, level, busy, read data      -      done
//   cfg       in         preamble length (write only)                 -      -
//
// one input beat is one MDC bit period; its result is ready the next cycle
// and a new beat is taken every cycle unless the result register is full
// and not being taken. the sequencer state advances once per accepted beat.
// reset clears the sequencer control state and the result valid flag and sets preamble to 40.
module mdio_clause22_master (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config
  input  logic                                cfg_we_i,
  input  logic [mdc22_pkg::PreW-1:0]          cfg_wdata_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [4:0] phy_address, [9:5] reg_address, [25:10] write_data, [26] data_line_in
  input  logic [mdc22_pkg::InTdataW-1:0]      s_axis_tdata,
  // [1:0] func
  input  logic [mdc22_pkg::FuncW-1:0]         s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] clock_pulse, [1] drive_enable, [2] drive_level, [3] busy_res, [19:4] read_data
  output logic [mdc22_pkg::OutTdataW-1:0]     m_axis_tdata,
  // done_res
  output logic                                m_axis_tlast
);

  logic [mdc22_pkg::PreW-1:0] pre_q;
  logic                       out_valid_q;
  mdc22_pkg::res_t            res_q;
  mdc22_pkg::res_t            res;
  logic                       step;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  // preamble length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= mdc22_pkg::PreambleReset;
    end else if (cfg_we_i) begin
      pre_q <= cfg_wdata_i;
    end
  end

  mdc22_sequencer u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .func_i         (s_axis_tuser),
    .phy_address_i  (s_axis_tdata[4:0]),
    .reg_address_i  (s_axis_tdata[9:5]),
    .write_data_i   (s_axis_tdata[25:10]),
    .data_line_in_i (s_axis_tdata[26]),
    .preamble_i     (pre_q),
    .res_o          (res)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, res_q.read_data, res_q.busy, res_q.drive_level,
                          res_q.drive_enable, res_q.clock_pulse};
  assign m_axis_tlast  = res_q.done;

endmodule
